### sv/odpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package odpq_pkg;

  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF    = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP        = 3'd4;

  localparam logic       OP_PIXEL = 1'b0;
  localparam logic       OP_LOAD  = 1'b1;

  typedef logic [7:0] dm_row_t [16];

  localparam dm_row_t DM16 [16] = '{
    '{8'd0, 8'd128, 8'd32, 8'd160, 8'd8, 8'd136, 8'd40, 8'd168,
      8'd2, 8'd130, 8'd34, 8'd162, 8'd10, 8'd138, 8'd42, 8'd170},
    '{8'd192, 8'd64, 8'd224, 8'd96, 8'd200, 8'd72, 8'd232, 8'd104,
      8'd194, 8'd66, 8'd226, 8'd98, 8'd202, 8'd74, 8'd234, 8'd106},
    '{8'd48, 8'd176, 8'd16, 8'd144, 8'd56, 8'd184, 8'd24, 8'd152,
      8'd50, 8'd178, 8'd18, 8'd146, 8'd58, 8'd186, 8'd26, 8'd154},
    '{8'd240, 8'd112, 8'd208, 8'd80, 8'd248, 8'd120, 8'd216, 8'd88,
      8'd242, 8'd114, 8'd210, 8'd82, 8'd250, 8'd122, 8'd218, 8'd90},
    '{8'd12, 8'd140, 8'd44, 8'd172, 8'd4, 8'd132, 8'd36, 8'd164,
      8'd14, 8'd142, 8'd46, 8'd174, 8'd6, 8'd134, 8'd38, 8'd166},
    '{8'd204, 8'd76, 8'd236, 8'd108, 8'd196, 8'd68, 8'd228, 8'd100,
      8'd206, 8'd78, 8'd238, 8'd110, 8'd198, 8'd70, 8'd230, 8'd102},
    '{8'd60, 8'd188, 8'd28, 8'd156, 8'd52, 8'd180, 8'd20, 8'd148,
      8'd62, 8'd190, 8'd30, 8'd158, 8'd54, 8'd182, 8'd22, 8'd150},
    '{8'd252, 8'd124, 8'd220, 8'd92, 8'd244, 8'd116, 8'd212, 8'd84,
      8'd254, 8'd126, 8'd222, 8'd94, 8'd246, 8'd118, 8'd214, 8'd86},
    '{8'd3, 8'd131, 8'd35, 8'd163, 8'd11, 8'd139, 8'd43, 8'd171,
      8'd1, 8'd129, 8'd33, 8'd161, 8'd9, 8'd137, 8'd41, 8'd169},
    '{8'd195, 8'd67, 8'd227, 8'd99, 8'd203, 8'd75, 8'd235, 8'd107,
      8'd193, 8'd65, 8'd225, 8'd97, 8'd201, 8'd73, 8'd233, 8'd105},
    '{8'd51, 8'd179, 8'd19, 8'd147, 8'd59, 8'd187, 8'd27, 8'd155,
      8'd49, 8'd177, 8'd17, 8'd145, 8'd57, 8'd185, 8'd25, 8'd153},
    '{8'd243, 8'd115, 8'd211, 8'd83, 8'd251, 8'd123, 8'd219, 8'd91,
      8'd241, 8'd113, 8'd209, 8'd81, 8'd249, 8'd121, 8'd217, 8'd89},
    '{8'd15, 8'd143, 8'd47, 8'd175, 8'd7, 8'd135, 8'd39, 8'd167,
      8'd13, 8'd141, 8'd45, 8'd173, 8'd5, 8'd133, 8'd37, 8'd165},
    '{8'd207, 8'd79, 8'd239, 8'd111, 8'd199, 8'd71, 8'd231, 8'd103,
      8'd205, 8'd77, 8'd237, 8'd109, 8'd197, 8'd69, 8'd229, 8'd101},
    '{8'd63, 8'd191, 8'd31, 8'd159, 8'd55, 8'd183, 8'd23, 8'd151,
      8'd61, 8'd189, 8'd29, 8'd157, 8'd53, 8'd181, 8'd21, 8'd149},
    '{8'd255, 8'd127, 8'd223, 8'd95, 8'd247, 8'd119, 8'd215, 8'd87,
      8'd253, 8'd125, 8'd221, 8'd93, 8'd245, 8'd117, 8'd213, 8'd85}};

  // item bundle handed from the offset pipe to the palette search
  typedef struct packed {
    logic        is_load;
    logic [3:0]  slot;
    logic [23:0] color;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } odpq_item_t;

  function automatic logic [15:0] swap16(input logic [15:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  // centred bayer value; 2*n*n is a power of two so the divide is a shift
  function automatic logic signed [8:0] bayer_base(input logic [1:0] code,
                                                   input logic [3:0] x,
                                                   input logic [3:0] y);
    logic [3:0]  mask;
    logic [7:0]  bv;
    logic [16:0] num;
    logic [8:0]  q;
    mask = 4'((5'd2 << code) - 5'd1);
    bv   = DM16[y & mask][x & mask] >> (3'd6 - 3'({code, 1'b0}));
    num  = ({8'd0, bv, 1'b1}) * 17'd255;
    q    = 9'(num >> (5'd3 + 5'({code, 1'b0})));
    return $signed(q) - 9'sd127;
  endfunction

endpackage
`default_nettype wire

### sv/odpq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface odpq_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [15:0]           pixel_in;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [3:0]            entry_index;
  logic [23:0]           entry_color;

  modport source (output valid, opcode, pixel_in, column, row, entry_index, entry_color,
                  input ready);
  modport sink (input valid, opcode, pixel_in, column, row, entry_index, entry_color,
                output ready);
endinterface
`default_nettype wire

### sv/odpq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface odpq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic [3:0]  chosen_index;

  modport source (output valid, pixel_out, chosen_index, input ready);
  modport sink (input valid, pixel_out, chosen_index, output ready);
endinterface
`default_nettype wire

### sv/odpq_search.sv
`timescale 1ns / 1ps
`default_nettype none
module odpq_search #(
  parameter int PALETTE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire odpq_pkg::odpq_item_t in_item,
  input  wire logic [8:0]        count,
  input  wire logic              swap,
  output logic                   out_valid,
  output logic [15:0]            out_pixel,
  output logic [3:0]             out_index
);
  import odpq_pkg::*;

  localparam int LANES = (PALETTE_DEPTH < 16) ? PALETTE_DEPTH : 16;
  localparam int IW    = $clog2(LANES);
  localparam int NG    = (LANES + 3) / 4;

  logic [23:0] pal_r [LANES];

  logic        v5_r, v6_r, v7_r;
  logic [17:0] d5_r [LANES];
  logic [15:0] c5_r [LANES];
  logic [17:0] bd6_r [NG];
  logic [IW-1:0] bi6_r [NG];
  logic [15:0] bc6_r [NG];
  logic [15:0] pix7_r;
  logic [3:0]  idx7_r;

  logic [17:0] d5_nxt [LANES];
  logic [15:0] c5_nxt [LANES];
  logic [17:0] bd6_nxt [NG];
  logic [IW-1:0] bi6_nxt [NG];
  logic [15:0] bc6_nxt [NG];
  logic [15:0] pix7_nxt;
  logic [3:0]  idx7_nxt;

  // palette written in order with the pixels that read it
  always_ff @(posedge clk) begin
    if (en && in_valid && in_item.is_load && (5'(in_item.slot) < 5'(LANES))) begin
      pal_r[in_item.slot[IW-1:0]] <= in_item.color;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic signed [8:0]  dr, dg, db;
      logic [17:0] sr, sg, sb;
      dr = $signed({1'b0, in_item.r}) - $signed({1'b0, pal_r[i][23:16]});
      dg = $signed({1'b0, in_item.g}) - $signed({1'b0, pal_r[i][15:8]});
      db = $signed({1'b0, in_item.b}) - $signed({1'b0, pal_r[i][7:0]});
      sr = $unsigned(18'(dr) * 18'(dr));
      sg = $unsigned(18'(dg) * 18'(dg));
      sb = $unsigned(18'(db) * 18'(db));
      d5_nxt[i] = (9'(i) < count) ? (sr + sg + sb) : '1;
      c5_nxt[i] = {pal_r[i][23:19], pal_r[i][15:10], pal_r[i][7:3]};
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      bd6_nxt[g] = d5_r[4*g];
      bi6_nxt[g] = IW'(4*g);
      bc6_nxt[g] = c5_r[4*g];
      for (int k = 1; k < 4; k++) begin
        if (4*g + k < LANES) begin
          if (d5_r[4*g+k] < bd6_nxt[g]) begin
            bd6_nxt[g] = d5_r[4*g+k];
            bi6_nxt[g] = IW'(4*g+k);
            bc6_nxt[g] = c5_r[4*g+k];
          end
        end
      end
    end
  end

  always_comb begin
    logic [17:0] bd;
    logic [15:0] bc;
    bd       = bd6_r[0];
    bc       = bc6_r[0];
    idx7_nxt = 4'(bi6_r[0]);
    for (int g = 1; g < NG; g++) begin
      if (bd6_r[g] < bd) begin
        bd       = bd6_r[g];
        bc       = bc6_r[g];
        idx7_nxt = 4'(bi6_r[g]);
      end
    end
    pix7_nxt = swap ? swap16(bc) : bc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= in_valid && !in_item.is_load;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_r   <= d5_nxt;
      c5_r   <= c5_nxt;
      bd6_r  <= bd6_nxt;
      bi6_r  <= bi6_nxt;
      bc6_r  <= bc6_nxt;
      pix7_r <= pix7_nxt;
      idx7_r <= idx7_nxt;
    end
  end

  assign out_valid = v7_r;
  assign out_pixel = pix7_r;
  assign out_index = idx7_r;

endmodule
`default_nettype wire

### sv/ordered_dither_palette_quantizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered-dither palette quantizer. A pixel transaction passes seven register
// stages (byte swap and bayer lookup, strength multiply, divide by one hundred
// and bias, clamp, per-entry distances, group minimum, final minimum and
// output register) before its result is offered on out_ch; one transaction
// can enter every cycle while the pipeline is not held. A load transaction
// gives no result; it updates the palette at the distance stage, so it is
// seen by exactly the pixels that follow it. The whole pipeline holds while a
// result waits on out_ch.ready. Up to 16 entries are searched in parallel.
module ordered_dither_palette_quantizer_unit #(
  parameter int PALETTE_DEPTH = odpq_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = odpq_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  odpq_in_if.sink                                 in_ch,
  odpq_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [odpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [odpq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import odpq_pkg::*;

  logic [1:0] msize_r;
  logic [4:0] pcount_r;
  logic [6:0] strength_r;
  logic [7:0] bias_r;
  logic       swap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_r    <= 2'd3;
      pcount_r   <= 5'd16;
      strength_r <= 7'd70;
      bias_r     <= 8'hFA;
      swap_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: msize_r    <= cfg_wdata[1:0];
        CFG_PAL_COUNT:   pcount_r   <= cfg_wdata[4:0];
        CFG_STRENGTH:    strength_r <= cfg_wdata[6:0];
        CFG_BIAS:        bias_r     <= cfg_wdata;
        CFG_SWAP:        swap_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [8:0] count;
  always_comb begin
    if (pcount_r == 5'd0) begin
      count = 9'd1;
    end else if (9'(pcount_r) > 9'(PALETTE_DEPTH)) begin
      count = 9'(PALETTE_DEPTH);
    end else begin
      count = 9'(pcount_r);
    end
  end

  logic en;
  logic srch_valid;
  assign en          = !srch_valid || out_ch.ready;
  assign in_ch.ready = en;

  logic v1_r, v2_r, v3_r, v4_r;
  odpq_item_t it1_r, it2_r, it3_r, it4_r;
  logic signed [8:0]  base1_r;
  logic signed [16:0] prod2_r;
  logic signed [9:0]  off3_r;

  odpq_item_t it1_nxt, it4_nxt;
  logic signed [8:0]  base1_nxt;
  logic signed [16:0] prod2_nxt;
  logic signed [9:0]  off3_nxt;
  logic [15:0] pix;

  always_comb begin
    pix             = swap_r ? swap16(in_ch.pixel_in) : in_ch.pixel_in;
    it1_nxt.is_load = (in_ch.opcode == OP_LOAD);
    it1_nxt.slot    = in_ch.entry_index;
    it1_nxt.color   = in_ch.entry_color;
    it1_nxt.r       = {pix[15:11], 3'b000};
    it1_nxt.g       = {pix[10:5], 2'b00};
    it1_nxt.b       = {pix[4:0], 3'b000};
    base1_nxt       = bayer_base(msize_r, in_ch.column[3:0], in_ch.row[3:0]);
  end

  assign prod2_nxt = 17'(base1_r * $signed({1'b0, strength_r}));

  // divide by 100 as multiply by 5243 over 2^19, exact below 43690
  always_comb begin
    logic [13:0] mag;
    logic [26:0] qm;
    logic [7:0]  q;
    mag = prod2_r[16] ? 14'($unsigned(-prod2_r)) : 14'($unsigned(prod2_r));
    qm  = 27'(mag) * 27'd5243;
    q   = 8'(qm >> 19);
    off3_nxt = (prod2_r[16] ? -$signed({2'b00, q}) : $signed({2'b00, q}))
               + 10'(signed'(bias_r));
  end

  function automatic logic [7:0] clamp_add(input logic [7:0] c,
                                           input logic signed [9:0] o);
    logic signed [10:0] s;
    s = $signed({3'b000, c}) + 11'(o);
    if (s < 0) return 8'd0;
    if (s > 11'sd255) return 8'd255;
    return s[7:0];
  endfunction

  always_comb begin
    it4_nxt   = it3_r;
    it4_nxt.r = clamp_add(it3_r.r, off3_r);
    it4_nxt.g = clamp_add(it3_r.g, off3_r);
    it4_nxt.b = clamp_add(it3_r.b, off3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= it1_nxt;
      base1_r <= base1_nxt;
      it2_r   <= it1_r;
      prod2_r <= prod2_nxt;
      it3_r   <= it2_r;
      off3_r  <= off3_nxt;
      it4_r   <= it4_nxt;
    end
  end

  odpq_search #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_item   (it4_r),
    .count     (count),
    .swap      (swap_r),
    .out_valid (srch_valid),
    .out_pixel (out_ch.pixel_out),
    .out_index (out_ch.chosen_index)
  );

  assign out_ch.valid = srch_valid;

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (9'(out_ch.chosen_index) < count))
    else $error("chosen index beyond searched entries");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result after reset");

endmodule
`default_nettype wire

### tb/odpq_quant_checker.sv
`timescale 1ns / 1ps
module odpq_quant_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  odpq_in_if                                  in_ch,
  odpq_out_if                                 out_ch,
  input  logic                                cfg_we,
  input  logic [odpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [odpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  pixel_count,
  output int                                  load_count
);
  import odpq_pkg::*;

  typedef struct packed {
    logic [15:0] pix;
    logic [3:0]  idx;
  } quant_t;

  quant_t      expected_q[$];
  logic [23:0] palette[16];
  logic [1:0]  mat_code;
  logic [4:0]  pal_count;
  logic [6:0]  strength;
  logic signed [7:0] bias;
  logic        swap_en;

  function automatic int clamp8(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic quant_t quantize(logic [15:0] word, logic [11:0] x, logic [11:0] y);
    int lg, n, bx, by, bv, base, off, r, g, b, cnt, best, best_d, d, dr, dg, db;
    logic [15:0] p;
    logic [23:0] c;
    quant_t res;
    p = swap_en ? {word[7:0], word[15:8]} : word;
    lg = int'(mat_code) + 1;
    n = 1 << lg;
    bx = int'(x) & (n - 1);
    by = int'(y) & (n - 1);
    bv = int'(DM16[by][bx]) >> (2 * (4 - lg));
    base = ((2 * bv + 1) * 255) / (2 * n * n) - 127;
    off = (base * int'(strength)) / 100 + int'(bias);
    r = clamp8(int'(p[15:11]) * 8 + off);
    g = clamp8(int'(p[10:5]) * 4 + off);
    b = clamp8(int'(p[4:0]) * 8 + off);
    cnt = (pal_count == 0) ? 1 : (pal_count > 16) ? 16 : int'(pal_count);
    best = 0;
    best_d = 32'h7fffffff;
    for (int i = 0; i < cnt; i++) begin
      dr = r - int'(palette[i][23:16]);
      dg = g - int'(palette[i][15:8]);
      db = b - int'(palette[i][7:0]);
      d = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    c = palette[best];
    res.pix = {c[23:19], c[15:10], c[7:3]};
    if (swap_en) res.pix = {res.pix[7:0], res.pix[15:8]};
    res.idx = 4'(best);
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    quant_t got, want;
    if (!rst_n) begin
      mat_code <= 2'd3;
      pal_count <= 5'd16;
      strength <= 7'd70;
      bias <= -8'sd6;
      swap_en <= 1'b1;
      fail_count <= 0;
      pixel_count <= 0;
      load_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATRIX_SIZE: mat_code <= cfg_wdata[1:0];
          CFG_PAL_COUNT:   pal_count <= cfg_wdata[4:0];
          CFG_STRENGTH:    strength <= cfg_wdata[6:0];
          CFG_BIAS:        bias <= $signed(cfg_wdata[7:0]);
          CFG_SWAP:        swap_en <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_LOAD) begin
          palette[in_ch.entry_index] = in_ch.entry_color;
          load_count <= load_count + 1;
        end else begin
          expected_q.push_back(quantize(in_ch.pixel_in, in_ch.column, in_ch.row));
          pixel_count <= pixel_count + 1;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pix = out_ch.pixel_out;
        got.idx = out_ch.chosen_index;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result pix=%h idx=%0d", got.pix, got.idx);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected pix=%h idx=%0d, got pix=%h idx=%0d",
                       want.pix, want.idx, got.pix, got.idx);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb_ordered_dither_palette_quantizer_unit.sv
`timescale 1ns / 1ps
module tb_ordered_dither_palette_quantizer_unit;
  import odpq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count, pending, pixel_count, load_count;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left;
  logic [23:0] shadow_pal[16];

  odpq_in_if #(.COORD_BITS(12)) in_ch ();
  odpq_out_if out_ch ();

  ordered_dither_palette_quantizer_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  odpq_quant_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending),
    .pixel_count(pixel_count), .load_count(load_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_go) hold_left <= 300;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_ch.ready <= !hold_go && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic send(logic op, logic [15:0] pix, logic [11:0] col, logic [11:0] row,
                      logic [3:0] idx, logic [23:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.pixel_in <= pix;
    in_ch.column <= col;
    in_ch.row <= row;
    in_ch.entry_index <= idx;
    in_ch.entry_color <= color;
    if (op == OP_LOAD) shadow_pal[idx] = color;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load(logic [3:0] idx, logic [23:0] color);
    send(OP_LOAD, 16'($urandom), 12'($urandom), 12'($urandom), idx, color);
  endtask

  task automatic pixel(logic [15:0] pix, logic [11:0] col, logic [11:0] row);
    send(OP_PIXEL, pix, col, row, 4'($urandom), 24'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(logic [1:0] msz, logic [7:0] cnt, logic [6:0] str,
                          logic [7:0] bs, logic sw);
    logic [7:0] vals[5];
    vals = '{8'(msz), cnt, 8'(str), bs, 8'(sw)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n_pix);
    int done;
    done = 0;
    while (done < n_pix) begin
      case ($urandom_range(9))
        0: load(4'($urandom), 24'($urandom));
        1: load(4'($urandom), shadow_pal[$urandom_range(15)]);
        2: pixel({shadow_pal[$urandom_range(15)][23:19], 11'($urandom)},
                 12'($urandom), 12'($urandom));
        default: pixel(16'($urandom), 12'($urandom), 12'($urandom));
      endcase
      if (in_ch.opcode == OP_PIXEL) done++;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PIXEL;
    in_ch.pixel_in = '0;
    in_ch.column = '0;
    in_ch.row = '0;
    in_ch.entry_index = '0;
    in_ch.entry_color = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    load(4'd0, 24'h000000);
    load(4'd1, 24'hFFFFFF);
    load(4'd2, 24'hFF0000);
    load(4'd3, 24'h00FF00);
    load(4'd4, 24'h0000FF);
    load(4'd5, 24'h000000);
    for (int i = 6; i < 15; i++) load(4'(i), 24'($urandom));
    load(4'd15, 24'hFFFFFF);
    pixel(16'h0000, 12'd0, 12'd0);
    pixel(16'hFFFF, 12'd4095, 12'd4095);
    pixel(16'h00F8, 12'd15, 12'd0);
    pixel(16'hE007, 12'd0, 12'd15);
    pixel(16'h1F00, 12'd4080, 12'd7);
    pixel(16'h5555, 12'hAAA, 12'h555);
    pixel(16'hAAAA, 12'h555, 12'hAAA);
    pixel(16'h8410, 12'd1, 12'd2);
    pixel(16'h0000, 12'd3, 12'd3);
    drain();

    // settings with extremes, each with its own handshake mode
    set_regs(2'd0, 8'd0, 7'd100, 8'h80, 1'b0);
    random_items(150);
    drain();
    send_idle_pct = 62;
    set_regs(2'd1, 8'd31, 7'd127, 8'h7F, 1'b1);
    random_items(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 62;
    set_regs(2'd2, 8'd17, 7'd0, 8'h00, 1'b0);
    random_items(150);
    drain();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    set_regs(2'd3, 8'd5, 7'd35, 8'hF0, 1'b1);
    random_items(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_regs(2'($urandom), 8'd16, 7'($urandom_range(100)), 8'($urandom), 1'($urandom));
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    random_items(150);
    drain();

    $display("covered %0d pixel and %0d palette load transactions", pixel_count, load_count);
    $display("over 6 register settings with idle, stall and hold-off phases");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### sim.f
sv/odpq_pkg.sv
sv/odpq_in_if.sv
sv/odpq_out_if.sv
sv/odpq_search.sv
sv/ordered_dither_palette_quantizer_unit.sv
tb/odpq_quant_checker.sv
tb/tb_ordered_dither_palette_quantizer_unit.sv
